// ----- src/cfd_pkg.sv -----
`default_nettype none
package cfd_pkg;

	// Width of the decoded byte counter: holds lengths up to 15.
	localparam int unsigned CNT_W = 4;

	typedef enum logic [1:0] {
		FS_OK        = 2'd0,
		FS_CSUM_ERR  = 2'd1,
		FS_FRAME_ERR = 2'd2
	} frame_status_t;

	// Header part of one frame result.
	typedef struct packed {
		frame_status_t status;
		logic [7:0]    sender;
		logic [7:0]    ptype;
	} frame_res_t;

endpackage
`default_nettype wire

// ----- src/cfd_frame_acc.sv -----
`default_nettype none
module cfd_frame_acc #(
	parameter int unsigned PAYLOAD_BYTES = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [7:0]                 byte_in,
	output cfd_pkg::frame_res_t             res,
	output logic [8*PAYLOAD_BYTES-1:0]      res_payload
);
	import cfd_pkg::*;

	localparam int unsigned PAY_W = 8 * PAYLOAD_BYTES;
	localparam logic [CNT_W-1:0] CHECK_POS   = CNT_W'(PAYLOAD_BYTES + 2);
	localparam logic [CNT_W-1:0] DECODED_LEN = CNT_W'(PAYLOAD_BYTES + 4);

	logic [7:0]       grp_q, grp_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       sum_q, sum_n;
	logic [7:0]       sender_q, sender_n;
	logic [7:0]       ptype_q, ptype_n;
	logic [PAY_W-1:0] pay_q, pay_n;
	logic [7:0]       check_q, check_n;
	logic             brk_q, brk_n;
	logic             app_lit, app_zero;

	always_comb begin
		grp_n    = grp_q;
		cnt_n    = cnt_q;
		sum_n    = sum_q;
		sender_n = sender_q;
		ptype_n  = ptype_q;
		pay_n    = pay_q;
		check_n  = check_q;
		brk_n    = brk_q;
		app_lit  = 1'b0;
		app_zero = 1'b0;

		if (byte_in != 8'd0) begin
			if (grp_q == 8'd0) begin
				// code byte opens a group
				grp_n    = byte_in - 8'd1;
				app_zero = (byte_in == 8'd1);
			end else begin
				grp_n    = grp_q - 8'd1;
				app_lit  = 1'b1;
				app_zero = (grp_q == 8'd1);
			end

			// literal byte
			if (app_lit && !brk_n) begin
				if (cnt_n >= DECODED_LEN) begin
					brk_n = 1'b1;
				end else begin
					if (cnt_n < CHECK_POS)
						sum_n = sum_n + byte_in;
					if (cnt_n == CNT_W'(0))
						sender_n = byte_in;
					if (cnt_n == CNT_W'(1))
						ptype_n = byte_in;
					for (int k = 0; k < PAYLOAD_BYTES; k++) begin
						if (cnt_n == CNT_W'(k + 2))
							pay_n[8*k +: 8] = byte_in;
					end
					if (cnt_n == CHECK_POS)
						check_n = byte_in;
					cnt_n = cnt_n + CNT_W'(1);
				end
			end

			// implied zero: holds are already zero at its position, only the count moves
			if (app_zero && !brk_n) begin
				if (cnt_n >= DECODED_LEN)
					brk_n = 1'b1;
				else
					cnt_n = cnt_n + CNT_W'(1);
			end
		end else begin
			// delimiter: back to an empty frame
			grp_n    = '0;
			cnt_n    = '0;
			sum_n    = '0;
			sender_n = '0;
			ptype_n  = '0;
			pay_n    = '0;
			check_n  = '0;
			brk_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			sender_q <= '0;
			ptype_q  <= '0;
			pay_q    <= '0;
			check_q  <= '0;
			brk_q    <= 1'b0;
		end else if (step) begin
			grp_q    <= grp_n;
			cnt_q    <= cnt_n;
			sum_q    <= sum_n;
			sender_q <= sender_n;
			ptype_q  <= ptype_n;
			pay_q    <= pay_n;
			check_q  <= check_n;
			brk_q    <= brk_n;
		end
	end

	// Verdict on the frame as it stands; used when the delimiter steps through.
	always_comb begin
		res.sender  = 8'd0;
		res.ptype   = 8'd0;
		res_payload = '0;
		if (brk_q || grp_q != 8'd0 || cnt_q != DECODED_LEN) begin
			res.status = FS_FRAME_ERR;
		end else if (sum_q != check_q) begin
			res.status = FS_CSUM_ERR;
		end else begin
			res.status  = FS_OK;
			res.sender  = sender_q;
			res.ptype   = ptype_q;
			res_payload = pay_q;
		end
	end

endmodule
`default_nettype wire

// ----- src/cfd_out_reg.sv -----
`default_nettype none
module cfd_out_reg #(
	parameter int unsigned PAYLOAD_BYTES = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire cfd_pkg::frame_res_t        res,
	input  wire logic [8*PAYLOAD_BYTES-1:0] res_payload,
	output logic                            free,
	output logic                            valid,
	input  wire logic                       ready,
	output cfd_pkg::frame_res_t             res_q,
	output logic [8*PAYLOAD_BYTES-1:0]      payload_q
);
	import cfd_pkg::*;

	logic valid_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q     <= res;
			payload_q <= res_payload;
		end
	end

endmodule
`default_nettype wire

// ----- src/cobs_packet_frame_decoder_core.sv -----
// COBS frame decoder: one link byte per transaction in, one frame result per delimiter out.
// Throughput: one byte per cycle except while a delimiter stalls; each byte passes one input
// register and one state update, results leave through a single output register.
// Stall: a delimiter waits in the input register while an unread result holds out_ready off.
// A delimiter's verdict is registered in the output register, which drives out_valid.
// Reset (arst_n low, asynchronous): empty frame, no group open, no result pending.
`default_nettype none
module cobs_packet_frame_decoder_core #(
	parameter int unsigned PAYLOAD_BYTES = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 rx_byte,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      frame_status,
	output logic [7:0]                      source_id,
	output logic [7:0]                      packet_type,
	output logic [8*PAYLOAD_BYTES-1:0]      payload
);
	import cfd_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       delim_s1;

	// Handshake between the stages
	logic       out_free;
	logic       step;
	logic       load;

	frame_res_t                 res;
	frame_res_t                 res_q;
	logic [8*PAYLOAD_BYTES-1:0] res_payload;

	assign delim_s1 = (byte_s1 == 8'd0);

	// Non-delimiter bytes never need the output side; a delimiter waits only
	// until the output register can take its result.
	assign step     = valid_s1 && (!delim_s1 || out_free);
	assign load     = step && delim_s1;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
	end

	// Group tracking, frame capture and checksum
	cfd_frame_acc #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.byte_in     (byte_s1),
		.res         (res),
		.res_payload (res_payload)
	);

	// Result register: frees the input side while a result waits downstream
	cfd_out_reg #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.res         (res),
		.res_payload (res_payload),
		.free        (out_free),
		.valid       (out_valid),
		.ready       (out_ready),
		.res_q       (res_q),
		.payload_q   (payload)
	);

	assign frame_status = res_q.status;
	assign source_id    = res_q.sender;
	assign packet_type  = res_q.ptype;

endmodule
`default_nettype wire
